### hw/rtl/jdd_pkg.sv
// Shared types, widths and constants for the joystick to differential drive block.
package jdd_pkg;

	localparam int ANGLE_W   = 9;
	localparam int STR_W     = 7;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int WHEEL_W   = 13;
	localparam int ANG_W     = 19;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 64;

	localparam int MS_W  = 19;  // max_speed * strength, up to 409500
	localparam int K_W   = 9;   // degree coefficient of the partial wheel
	localparam int KMS_W = 28;  // coefficient * max_speed * strength
	localparam int PROD_W = 23; // |right - left| * 1000

	localparam int DIV_NW = 28; // dividend width, one quotient bit per stage
	localparam int DIV_DW = 14; // divisor width

	// floor(x / 100) = (x * RCP_PCT) >> RCP_PCT_SH, exact for x < 2**19
	localparam int RCP_PCT_W  = 20;
	localparam int RCP_PCT_SH = 26;
	// floor(x / 9000) = (x * RCP_FWD) >> RCP_FWD_SH, exact for x < 2**28
	localparam int RCP_FWD_W  = 28;
	localparam int RCP_FWD_SH = 41;
	localparam int PART_W     = 15; // wheel quotient before saturation, up to 23250

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic [CFG_W-1:0]     MAX_SPEED_RST  = 12'd500;
	localparam logic [CFG_W-1:0]     WHEEL_BASE_RST = 12'd400;
	localparam logic [STR_W-1:0]     STR_MAX        = 7'd100;
	localparam logic [RCP_PCT_W-1:0] RCP_PCT        = 20'd671089;
	localparam logic [RCP_FWD_W-1:0] RCP_FWD        = 28'd244335918;
	localparam logic [WHEEL_W-2:0]   WHEEL_LIM      = 12'd4095;
	localparam logic [ANG_W-2:0]     ANG_LIM        = 18'd262143;
	localparam logic [9:0]           MRAD_SCALE     = 10'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED  = 1'b0,
		REG_WHEEL_BASE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_FULL,
		SRC_PART
	} wheel_src_t;

	typedef struct packed {
		wheel_src_t left_src;
		wheel_src_t right_src;
		logic       left_neg;
		logic       right_neg;
		logic       bwd;
	} drive_ctl_t;

	typedef struct packed {
		drive_ctl_t        ctl;
		logic [MS_W-1:0]   ms;
		logic [KMS_W-1:0]  kms;
	} cmd_t;

	typedef struct packed {
		logic [WHEEL_W-1:0] left;
		logic [WHEEL_W-1:0] right;
		logic [WHEEL_W-1:0] lin;
		logic               neg;
		logic               wb_zero;
	} ang_side_t;

endpackage

### hw/rtl/joystick_to_differential_drive.sv
// Joystick to differential drive: top level with configuration registers.
//
// Input stream: s_axis_tdata carries one joystick command (angle, strength).
// Output stream: m_axis_tdata carries left and right wheel speeds, linear
// speed and yaw rate, all two's complement.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (0 max speed, 1 wheel base); write only while no command is in flight.
// Throughput: one command per cycle unless a stalled receiver has filled the queue. Each command is independent.
// Path from acceptance to m_axis_tvalid: the front stages, one queue slot,
// three back stages (reciprocal multiplies for the wheel quotients, wheel
// speeds, yaw product), a 28-stage restoring divider by the wheel base and
// the output register.
// The front end runs on its own until the 4-entry queue fills; the back end
// advances only when its output register is empty or taken, so a stalled
// receiver freezes the back pipeline, then fills the queue, then drops
// s_axis_tready.
// Reset clears all valid state and loads max speed 500 and wheel base 400.
module joystick_to_differential_drive
	import jdd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// [8:0] angle_deg, [15:9] strength_pct
	input  logic [IN_DATA_W-1:0]    s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// [12:0] left_mm_s, [25:13] right_mm_s, [38:26] linear_mm_s,
	// [57:39] angular_mrad_s, [63:58] zero
	output logic [OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	logic [CFG_W-1:0]   max_speed_q;
	logic [CFG_W-1:0]   wheel_base_q;

	logic               push;
	cmd_t               push_cmd;
	logic               q_full;
	logic               pop;
	logic               head_valid;
	cmd_t               head_cmd;

	logic [WHEEL_W-1:0] left_mm_s;
	logic [WHEEL_W-1:0] right_mm_s;
	logic [WHEEL_W-1:0] linear_mm_s;
	logic [ANG_W-1:0]   angular_mrad_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= MAX_SPEED_RST;
			wheel_base_q <= WHEEL_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_SPEED:  max_speed_q  <= cfg_data;
				REG_WHEEL_BASE: wheel_base_q <= cfg_data;
			endcase
		end
	end

	jdd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.angle_deg    (s_axis_tdata[ANGLE_W-1:0]),
		.strength_pct (s_axis_tdata[ANGLE_W+STR_W-1:ANGLE_W]),
		.max_speed    (max_speed_q),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_full       (q_full)
	);

	jdd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	jdd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.wheel_base     (wheel_base_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.left_mm_s      (left_mm_s),
		.right_mm_s     (right_mm_s),
		.linear_mm_s    (linear_mm_s),
		.angular_mrad_s (angular_mrad_s)
	);

	assign m_axis_tdata = {
		(OUT_DATA_W - 3*WHEEL_W - ANG_W)'(0),
		angular_mrad_s, linear_mm_s, right_mm_s, left_mm_s
	};

endmodule

### hw/rtl/jdd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module jdd_div
	import jdd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              out_valid,
	output logic [DIV_NW-1:0] quotient
);

	logic [DIV_DW-1:0] rem_q [DIV_NW];
	logic [DIV_NW-1:0] nq_q  [DIV_NW];
	logic [DIV_DW-1:0] d_q   [DIV_NW];
	logic [DIV_NW-1:0] vld_q;

	logic [DIV_DW-1:0] src_rem [DIV_NW];
	logic [DIV_NW-1:0] src_nq  [DIV_NW];
	logic [DIV_DW-1:0] src_d   [DIV_NW];
	logic [DIV_NW-1:0] src_v;
	logic [DIV_DW:0]   tmp     [DIV_NW];
	logic [DIV_NW-1:0] fit;
	logic [DIV_DW-1:0] rem_n   [DIV_NW];

	always_comb begin
		src_rem[0] = '0;
		src_nq[0]  = dividend;
		src_d[0]   = divisor;
		src_v[0]   = in_valid;
		for (int i = 1; i < DIV_NW; i++) begin
			src_rem[i] = rem_q[i-1];
			src_nq[i]  = nq_q[i-1];
			src_d[i]   = d_q[i-1];
			src_v[i]   = vld_q[i-1];
		end
		for (int i = 0; i < DIV_NW; i++) begin
			// shift in the next dividend bit, subtract when it fits
			tmp[i]   = {src_rem[i], src_nq[i][DIV_NW-1]};
			fit[i]   = (tmp[i] >= {1'b0, src_d[i]});
			rem_n[i] = fit[i] ? DIV_DW'(tmp[i] - {1'b0, src_d[i]}) : tmp[i][DIV_DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= src_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_NW; i++) begin
				rem_q[i] <= rem_n[i];
				nq_q[i]  <= {src_nq[i][DIV_NW-2:0], fit[i]};
				d_q[i]   <= src_d[i];
			end
		end
	end

	assign out_valid = vld_q[DIV_NW-1];
	assign quotient  = nq_q[DIV_NW-1];

endmodule

### hw/rtl/jdd_front.sv
// Front end: clamp strength, classify the angle region and form the products.
module jdd_front
	import jdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ANGLE_W-1:0] angle_deg,
	input  logic [STR_W-1:0]   strength_pct,
	input  logic [CFG_W-1:0]   max_speed,
	output logic               push,
	output cmd_t               push_cmd,
	input  logic               q_full
);

	logic               en;
	logic [STR_W-1:0]   str_c;
	drive_ctl_t         ctl_n;
	logic [K_W-1:0]     k_n;

	logic               vld_s1;
	drive_ctl_t         ctl_s1;
	logic [K_W-1:0]     k_s1;
	logic [MS_W-1:0]    ms_s1;

	logic               vld_s2;
	drive_ctl_t         ctl_s2;
	logic [MS_W-1:0]    ms_s2;
	logic [KMS_W-1:0]   kms_s2;

	assign en       = !vld_s2 || !q_full;
	assign in_ready = en;
	assign str_c    = (strength_pct > STR_MAX) ? STR_MAX : strength_pct;

	always_comb begin
		ctl_n = '{left_src: SRC_ZERO, right_src: SRC_ZERO,
			left_neg: 1'b0, right_neg: 1'b0, bwd: 1'b0};
		k_n   = '0;
		priority if (angle_deg > 9'd90 && angle_deg <= 9'd180) begin
			ctl_n.right_src = SRC_FULL;
			ctl_n.left_src  = SRC_PART;
			k_n             = 9'd180 - angle_deg;
		end else if (angle_deg > 9'd180 && angle_deg <= 9'd190) begin
			ctl_n.right_src = SRC_FULL;
		end else if (angle_deg > 9'd190 && angle_deg <= 9'd225) begin
			ctl_n.bwd = 1'b0;
		end else if (angle_deg > 9'd225 && angle_deg <= 9'd270) begin
			ctl_n.right_src = SRC_FULL;
			ctl_n.left_src  = SRC_PART;
			ctl_n.right_neg = 1'b1;
			ctl_n.left_neg  = 1'b1;
			ctl_n.bwd       = 1'b1;
			k_n             = angle_deg - 9'd225;
		end else if (angle_deg > 9'd270 && angle_deg <= 9'd315) begin
			ctl_n.left_src  = SRC_FULL;
			ctl_n.right_src = SRC_PART;
			ctl_n.right_neg = 1'b1;
			ctl_n.left_neg  = 1'b1;
			ctl_n.bwd       = 1'b1;
			k_n             = 9'd315 - angle_deg;
		end else if (angle_deg > 9'd315 && angle_deg <= 9'd350) begin
			ctl_n.bwd = 1'b0;
		end else if (angle_deg > 9'd350 && angle_deg <= 9'd360) begin
			ctl_n.left_src = SRC_FULL;
		end else begin
			// first arc, also zero and anything past a full turn
			ctl_n.left_src  = SRC_FULL;
			ctl_n.right_src = SRC_PART;
			k_n             = angle_deg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_n;
			k_s1   <= k_n;
			ms_s1  <= MS_W'(max_speed) * MS_W'(str_c);
			ctl_s2 <= ctl_s1;
			ms_s2  <= ms_s1;
			kms_s2 <= KMS_W'(k_s1) * KMS_W'(ms_s1);
		end
	end

	assign push     = vld_s2 && !q_full;
	assign push_cmd = '{ctl: ctl_s2, ms: ms_s2, kms: kms_s2};

endmodule

### hw/rtl/jdd_queue.sv
// Short command queue between the front end and the divider back end.
module jdd_queue
	import jdd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count past depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");

endmodule

### hw/rtl/jdd_back.sv
// Back end: wheel speed quotients, saturation, linear speed and yaw rate divide.
module jdd_back
	import jdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  cmd_t               head_cmd,
	output logic               pop,
	input  logic [CFG_W-1:0]   wheel_base,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WHEEL_W-1:0] left_mm_s,
	output logic [WHEEL_W-1:0] right_mm_s,
	output logic [WHEEL_W-1:0] linear_mm_s,
	output logic [ANG_W-1:0]   angular_mrad_s
);

	logic en;

	logic [KMS_W-1:0]                kms_scaled;
	logic [MS_W+RCP_PCT_W-1:0]       prod_full;
	logic [KMS_W+RCP_FWD_W-1:0]      prod_part;

	logic              vld_s1;
	drive_ctl_t        ctl_s1;
	logic [PART_W-1:0] qa_s1;
	logic [PART_W-1:0] qb_s1;

	logic               vld_s2;
	logic [WHEEL_W-1:0] left_s2;
	logic [WHEEL_W-1:0] right_s2;

	logic signed [WHEEL_W:0] diff;
	logic signed [WHEEL_W:0] sum;
	logic signed [WHEEL_W:0] sum_adj;
	logic [WHEEL_W:0]        abs_diff;

	logic              vld_s3;
	logic [PROD_W-1:0] prod_s3;
	ang_side_t         side_s3;

	logic              dc_valid;
	logic [DIV_NW-1:0] qc;
	ang_side_t         side_q [DIV_NW];
	ang_side_t         side_out;
	logic [ANG_W-2:0]  ang_mag;

	logic               vld_s4;
	logic [WHEEL_W-1:0] left_s4;
	logic [WHEEL_W-1:0] right_s4;
	logic [WHEEL_W-1:0] lin_s4;
	logic [ANG_W-1:0]   ang_s4;

	function automatic logic [WHEEL_W-1:0] wheel_val(
		input wheel_src_t        src,
		input logic              neg,
		input logic [PART_W-1:0] full,
		input logic [PART_W-1:0] part
	);
		logic [PART_W-1:0]  raw;
		logic [WHEEL_W-1:0] mag;
		unique case (src)
			SRC_FULL: raw = full;
			SRC_PART: raw = part;
			default:  raw = '0;
		endcase
		mag = (raw > PART_W'(WHEEL_LIM)) ? {1'b0, WHEEL_LIM} : raw[WHEEL_W-1:0];
		return neg ? WHEEL_W'(-mag) : mag;
	endfunction

	// the whole back end stalls together behind the output register
	assign en  = !vld_s4 || out_ready;
	assign pop = en && head_valid;

	// quotients by 100 and 9000 as reciprocal multiplies; a backward arc
	// divides by 4500, so double its dividend
	always_comb begin
		kms_scaled = head_cmd.ctl.bwd ? {head_cmd.kms[KMS_W-2:0], 1'b0} : head_cmd.kms;
		prod_full  = (MS_W+RCP_PCT_W)'(head_cmd.ms) * (MS_W+RCP_PCT_W)'(RCP_PCT);
		prod_part  = (KMS_W+RCP_FWD_W)'(kms_scaled) * (KMS_W+RCP_FWD_W)'(RCP_FWD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= head_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= dc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= head_cmd.ctl;
			qa_s1  <= PART_W'(prod_full[MS_W+RCP_PCT_W-1:RCP_PCT_SH]);
			qb_s1  <= prod_part[KMS_W+RCP_FWD_W-1:RCP_FWD_SH];
		end
	end

	// wheel speeds
	always_ff @(posedge clk) begin
		if (en) begin
			left_s2  <= wheel_val(ctl_s1.left_src, ctl_s1.left_neg, qa_s1, qb_s1);
			right_s2 <= wheel_val(ctl_s1.right_src, ctl_s1.right_neg, qa_s1, qb_s1);
		end
	end

	// linear speed and wheel difference
	always_comb begin
		diff     = $signed({right_s2[WHEEL_W-1], right_s2})
			- $signed({left_s2[WHEEL_W-1], left_s2});
		sum      = $signed({right_s2[WHEEL_W-1], right_s2})
			+ $signed({left_s2[WHEEL_W-1], left_s2});
		abs_diff = diff[WHEEL_W] ? (WHEEL_W+1)'(-diff) : diff;
		// round a negative half toward zero before the shift
		sum_adj  = sum + $signed({{WHEEL_W{1'b0}}, sum[WHEEL_W]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3         <= PROD_W'(abs_diff) * PROD_W'(MRAD_SCALE);
			side_s3.left    <= left_s2;
			side_s3.right   <= right_s2;
			side_s3.lin     <= sum_adj[WHEEL_W:1];
			side_s3.neg     <= diff[WHEEL_W];
			side_s3.wb_zero <= (wheel_base == '0);
		end
	end

	jdd_div u_div_ang (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.dividend  (DIV_NW'(prod_s3)),
		.divisor   (DIV_DW'(wheel_base)),
		.out_valid (dc_valid),
		.quotient  (qc)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s3;
			for (int i = 1; i < DIV_NW; i++) side_q[i] <= side_q[i-1];
		end
	end

	assign side_out = side_q[DIV_NW-1];
	assign ang_mag  = (qc > DIV_NW'(ANG_LIM)) ? ANG_LIM : qc[ANG_W-2:0];

	always_ff @(posedge clk) begin
		if (en) begin
			left_s4  <= side_out.left;
			right_s4 <= side_out.right;
			lin_s4   <= side_out.lin;
			if (side_out.wb_zero) begin
				ang_s4 <= '0;
			end else begin
				ang_s4 <= side_out.neg ? ANG_W'(-{1'b0, ang_mag}) : {1'b0, ang_mag};
			end
		end
	end

	assign out_valid      = vld_s4;
	assign left_mm_s      = left_s4;
	assign right_mm_s     = right_s4;
	assign linear_mm_s    = lin_s4;
	assign angular_mrad_s = ang_s4;

	a_full_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> qa_s1 <= PART_W'(WHEEL_LIM))
		else $error("full wheel speed exceeds limit");
	a_bwd_part_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && ctl_s1.bwd) |-> qb_s1 <= PART_W'(WHEEL_LIM))
		else $error("backward partial wheel speed exceeds limit");
	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (left_s2 != 13'h1000 && right_s2 != 13'h1000))
		else $error("wheel speed outside saturation range");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !out_ready) |=> $stable(ang_s4) && vld_s4)
		else $error("result changed while stalled");

endmodule
